>>> rtl/core/dpr_pkg.sv
// types and constants shared by the delta patch record parser
`default_nettype none
package dpr_pkg;

    typedef enum logic [3:0] {
        PH_MAGIC   = 4'd0,
        PH_CKLEN   = 4'd1,
        PH_SRCSIZE = 4'd2,
        PH_SRCCK   = 4'd3,
        PH_DSTSIZE = 4'd4,
        PH_DSTCK   = 4'd5,
        PH_RECLEN  = 4'd6,
        PH_COPYOFF = 4'd7,
        PH_COPYLEN = 4'd8,
        PH_LITERAL = 4'd9
    } t_phase;

    typedef enum logic [2:0] {
        K_NONE     = 3'd0,
        K_LITERAL  = 3'd1,
        K_COPY     = 3'd2,
        K_SRC_SIZE = 3'd3,
        K_SRC_CK   = 3'd4,
        K_DST_SIZE = 3'd5,
        K_DST_CK   = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TRUNC    = 2'd1,
        ST_MISMATCH = 2'd2
    } t_status;

    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        logic [7:0] patch_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [31:0] field_value;
        logic [31:0] copy_length;
        logic        done_res;
        t_status     status;
    } t_res;

    // classified byte handed from the parser to the output side
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [31:0] field_value;
        logic [31:0] copy_length;
        logic        last;
        logic        trunc;
    } t_cmd;

endpackage
`default_nettype wire

>>> rtl/core/dpr_front.sv
// parse front: phase tracking, field collection and byte classification
`default_nettype none
module dpr_front #(
    parameter int MAGIC_LEN = 4,
    parameter int LEN_BYTES = 2
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_accept,
    input  wire dpr_pkg::t_item i_item,
    input  wire                 i_cfg_wr_en,
    input  wire [15:0]          i_cfg_wr_data,
    output dpr_pkg::t_cmd       o_cmd
);

    localparam dpr_pkg::t_phase START_PHASE =
        (MAGIC_LEN == 0) ? dpr_pkg::PH_CKLEN : dpr_pkg::PH_MAGIC;

    dpr_pkg::t_phase r_phase, n_phase;
    logic [31:0]     r_bc, n_bc;
    logic [31:0]     r_acc, n_acc;
    logic [31:0]     r_cklen, n_cklen;
    logic [31:0]     r_off, n_off;
    logic [15:0]     r_marker;

    logic [31:0] bc_inc;
    logic [31:0] acc_sum;
    logic        done4;
    logic        done_len;

    always_comb begin
        bc_inc   = r_bc + 32'd1;
        acc_sum  = r_acc | (32'(i_item.patch_byte) << {r_bc[1:0], 3'b000});
        done4    = (bc_inc >= 32'd4);
        done_len = (bc_inc >= 32'(LEN_BYTES));

        n_phase = r_phase;
        n_bc    = r_bc;
        n_acc   = r_acc;
        n_cklen = r_cklen;
        n_off   = r_off;
        o_cmd   = '0;
        o_cmd.last = i_item.last_byte;

        unique case (r_phase)
            dpr_pkg::PH_MAGIC: begin
                n_bc = bc_inc;
                if (bc_inc >= 32'(MAGIC_LEN)) begin
                    n_bc    = '0;
                    n_phase = dpr_pkg::PH_CKLEN;
                end
            end
            dpr_pkg::PH_CKLEN: begin
                n_bc  = bc_inc;
                n_acc = acc_sum;
                if (done4) begin
                    n_cklen = acc_sum;
                    n_bc    = '0;
                    n_acc   = '0;
                    n_phase = dpr_pkg::PH_SRCSIZE;
                end
            end
            dpr_pkg::PH_SRCSIZE: begin
                n_bc  = bc_inc;
                n_acc = acc_sum;
                if (done4) begin
                    o_cmd.kind        = dpr_pkg::K_SRC_SIZE;
                    o_cmd.field_value = acc_sum;
                    n_bc    = '0;
                    n_acc   = '0;
                    n_phase = (r_cklen != '0) ? dpr_pkg::PH_SRCCK : dpr_pkg::PH_DSTSIZE;
                end
            end
            dpr_pkg::PH_SRCCK: begin
                o_cmd.kind      = dpr_pkg::K_SRC_CK;
                o_cmd.data_byte = i_item.patch_byte;
                n_bc = bc_inc;
                if (bc_inc >= r_cklen) begin
                    n_bc    = '0;
                    n_phase = dpr_pkg::PH_DSTSIZE;
                end
            end
            dpr_pkg::PH_DSTSIZE: begin
                n_bc  = bc_inc;
                n_acc = acc_sum;
                if (done4) begin
                    o_cmd.kind        = dpr_pkg::K_DST_SIZE;
                    o_cmd.field_value = acc_sum;
                    n_bc    = '0;
                    n_acc   = '0;
                    n_phase = (r_cklen != '0) ? dpr_pkg::PH_DSTCK : dpr_pkg::PH_RECLEN;
                end
            end
            dpr_pkg::PH_DSTCK: begin
                o_cmd.kind      = dpr_pkg::K_DST_CK;
                o_cmd.data_byte = i_item.patch_byte;
                n_bc = bc_inc;
                if (bc_inc >= r_cklen) begin
                    n_bc    = '0;
                    n_phase = dpr_pkg::PH_RECLEN;
                end
            end
            dpr_pkg::PH_RECLEN: begin
                n_bc  = bc_inc;
                n_acc = acc_sum;
                if (done_len) begin
                    n_bc  = '0;
                    n_acc = '0;
                    if (acc_sum == {16'd0, r_marker}) begin
                        n_phase = dpr_pkg::PH_COPYOFF;
                    end else if (acc_sum != '0) begin
                        n_bc    = acc_sum;
                        n_phase = dpr_pkg::PH_LITERAL;
                    end
                end
            end
            dpr_pkg::PH_COPYOFF: begin
                n_bc  = bc_inc;
                n_acc = acc_sum;
                if (done4) begin
                    n_off   = acc_sum;
                    n_bc    = '0;
                    n_acc   = '0;
                    n_phase = dpr_pkg::PH_COPYLEN;
                end
            end
            dpr_pkg::PH_COPYLEN: begin
                n_bc  = bc_inc;
                n_acc = acc_sum;
                if (done4) begin
                    o_cmd.kind        = dpr_pkg::K_COPY;
                    o_cmd.field_value = r_off;
                    o_cmd.copy_length = acc_sum;
                    n_bc    = '0;
                    n_acc   = '0;
                    n_phase = dpr_pkg::PH_RECLEN;
                end
            end
            dpr_pkg::PH_LITERAL: begin
                o_cmd.kind      = dpr_pkg::K_LITERAL;
                o_cmd.data_byte = i_item.patch_byte;
                if (r_bc != '0) begin
                    n_bc = r_bc - 32'd1;
                end
                if (r_bc <= 32'd1) begin
                    n_phase = dpr_pkg::PH_RECLEN;
                end
            end
            default: begin
                n_phase = START_PHASE;
                n_bc    = '0;
                n_acc   = '0;
            end
        endcase

        o_cmd.trunc = (n_phase != dpr_pkg::PH_RECLEN) || (n_bc != '0);

        if (i_item.last_byte) begin
            n_phase = START_PHASE;
            n_bc    = '0;
            n_acc   = '0;
            n_cklen = '0;
            n_off   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= START_PHASE;
            r_bc     <= '0;
            r_acc    <= '0;
            r_cklen  <= '0;
            r_off    <= '0;
            r_marker <= 16'd4096;
        end else begin
            if (i_accept) begin
                r_phase <= n_phase;
                r_bc    <= n_bc;
                r_acc   <= n_acc;
                r_cklen <= n_cklen;
                r_off   <= n_off;
            end
            if (i_cfg_wr_en) begin
                r_marker <= i_cfg_wr_data;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/dpr_fifo.sv
// two entry queue between the parse front and the output side
`default_nettype none
module dpr_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire dpr_pkg::t_cmd  i_cmd,
    input  wire                 i_pop,
    output dpr_pkg::t_cmd       o_cmd,
    output logic                o_full,
    output logic                o_empty
);

    localparam int PW = (dpr_pkg::FIFO_DEPTH > 1) ? $clog2(dpr_pkg::FIFO_DEPTH) : 1;
    localparam int CW = $clog2(dpr_pkg::FIFO_DEPTH + 1);

    dpr_pkg::t_cmd r_mem [dpr_pkg::FIFO_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CW'(dpr_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(dpr_pkg::FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(dpr_pkg::FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/dpr_back.sv
// output side: produced count, size check, status and output register
`default_nettype none
module dpr_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_empty,
    input  wire dpr_pkg::t_cmd  i_cmd,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_stall,
    output dpr_pkg::t_res       o_res
);

    logic [31:0]   r_produced, n_produced;
    logic [31:0]   r_dest, n_dest;
    logic          r_valid;
    dpr_pkg::t_res r_res, n_res;

    logic [31:0] add_val;
    logic [32:0] sum;

    assign o_pop   = !i_empty && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        case (i_cmd.kind)
            dpr_pkg::K_LITERAL: add_val = 32'd1;
            dpr_pkg::K_COPY:    add_val = i_cmd.copy_length;
            default:            add_val = '0;
        endcase
        sum        = {1'b0, r_produced} + {1'b0, add_val};
        n_produced = sum[32] ? '1 : sum[31:0];
        n_dest     = (i_cmd.kind == dpr_pkg::K_DST_SIZE) ? i_cmd.field_value : r_dest;

        n_res.kind        = i_cmd.kind;
        n_res.data_byte   = i_cmd.data_byte;
        n_res.field_value = i_cmd.field_value;
        n_res.copy_length = i_cmd.copy_length;
        n_res.done_res    = i_cmd.last;
        if (!i_cmd.last) begin
            n_res.status = dpr_pkg::ST_OK;
        end else if (i_cmd.trunc) begin
            n_res.status = dpr_pkg::ST_TRUNC;
        end else if (n_produced != n_dest) begin
            n_res.status = dpr_pkg::ST_MISMATCH;
        end else begin
            n_res.status = dpr_pkg::ST_OK;
        end

        if (i_cmd.last) begin
            n_produced = '0;
            n_dest     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_produced <= '0;
            r_dest     <= '0;
        end else begin
            if (o_pop) begin
                r_valid    <= 1'b1;
                r_produced <= n_produced;
                r_dest     <= n_dest;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/delta_patch_record_parser.sv
// top level of the delta patch record parser
//
//  channel  direction  handshake                     payload
//  in       input      i_in_valid / o_in_stall       i_in_item  (t_item)
//  out      output     o_out_valid / i_out_stall     o_out_res  (t_res)
//  cfg      input      i_cfg_wr_en                   i_cfg_wr_data (copy marker)
//
//  one byte a cycle while the queue has room; the front parser updates phase and fields
//  a result goes from the parser into the queue and then into the output register
//  the two entry queue lets the front keep accepting while the output is stalled
//  o_in_stall is high only while the queue is full
//  synchronous active low reset, no clearing pass
`default_nettype none
module delta_patch_record_parser #(
    parameter int MAGIC_LEN = 4,
    parameter int LEN_BYTES = 2
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire dpr_pkg::t_item  i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output dpr_pkg::t_res        o_out_res,
    input  wire                  i_cfg_wr_en,
    input  wire [15:0]           i_cfg_wr_data
);

    dpr_pkg::t_cmd w_front_cmd;
    dpr_pkg::t_cmd w_queue_cmd;
    logic          w_full;
    logic          w_empty;
    logic          w_pop;
    logic          w_accept;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    dpr_front #(
        .MAGIC_LEN (MAGIC_LEN),
        .LEN_BYTES (LEN_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_item        (i_in_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cmd         (w_front_cmd)
    );

    dpr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_queue_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    dpr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_cmd   (w_queue_cmd),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (o_out_res)
    );

    a_no_out_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_out_valid)
        else $error("output valid right after reset");

    a_queue_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_full && w_empty))
        else $error("queue full and empty at once");

    a_status_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_res.done_res) |-> (o_out_res.status == dpr_pkg::ST_OK))
        else $error("status set without done");

    a_literal_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_res.kind == dpr_pkg::K_LITERAL) |->
        (o_out_res.field_value == '0 && o_out_res.copy_length == '0))
        else $error("literal result carries field values");

    a_accept_fills_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !w_empty)
        else $error("accepted transfer did not reach the queue");

endmodule
`default_nettype wire

>>> tb/sv/delta_patch_record_parser_test.sv
// self-checking testbench for the delta patch record parser with a byte-level predictor
`timescale 1ns / 100ps
module delta_patch_record_parser_test;

    localparam int CLK_PERIOD     = 4;
    localparam int MAGIC_LEN      = 4;
    localparam int LEN_BYTES      = 2;
    localparam int ITEMS          = 950;
    localparam int HOLD_AT        = 150;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    class record_scoreboard;
        dpr_pkg::t_res   pending[$];
        logic [15:0]     marker;
        dpr_pkg::t_phase phase;
        logic [31:0]     cnt;
        logic [31:0]     accum;
        logic [31:0]     ck_len;
        logic [31:0]     dest_len;
        logic [31:0]     copy_off;
        logic [31:0]     produced;
        int              errors;

        function new();
            marker = 16'd4096;
            errors = 0;
            clear_state();
        endfunction

        static function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function void drop_field();
            cnt = 0;
            accum = 0;
        endfunction

        function void clear_state();
            phase = (MAGIC_LEN == 0) ? dpr_pkg::PH_CKLEN : dpr_pkg::PH_MAGIC;
            ck_len = 0;
            dest_len = 0;
            copy_off = 0;
            produced = 0;
            drop_field();
        endfunction

        // little-endian field collection, true once n bytes are in
        function bit take(logic [7:0] b, int unsigned n);
            if (cnt < 4)
                accum = accum | ({24'd0, b} << (8 * cnt));
            cnt = cnt + 1;
            return cnt >= n;
        endfunction

        function void parse_byte(dpr_pkg::t_item it);
            dpr_pkg::t_res r;
            logic [7:0]    b;
            logic [31:0]   v;
            r = '0;
            b = it.patch_byte;
            case (phase)
                dpr_pkg::PH_MAGIC: begin
                    cnt = cnt + 1;
                    if (cnt >= MAGIC_LEN) begin
                        cnt = 0;
                        phase = dpr_pkg::PH_CKLEN;
                    end
                end
                dpr_pkg::PH_CKLEN: begin
                    if (take(b, 4)) begin
                        ck_len = accum;
                        drop_field();
                        phase = dpr_pkg::PH_SRCSIZE;
                    end
                end
                dpr_pkg::PH_SRCSIZE: begin
                    if (take(b, 4)) begin
                        r.kind = dpr_pkg::K_SRC_SIZE;
                        r.field_value = accum;
                        drop_field();
                        phase = (ck_len != 0) ? dpr_pkg::PH_SRCCK : dpr_pkg::PH_DSTSIZE;
                    end
                end
                dpr_pkg::PH_SRCCK: begin
                    r.kind = dpr_pkg::K_SRC_CK;
                    r.data_byte = b;
                    cnt = cnt + 1;
                    if (cnt >= ck_len) begin
                        cnt = 0;
                        phase = dpr_pkg::PH_DSTSIZE;
                    end
                end
                dpr_pkg::PH_DSTSIZE: begin
                    if (take(b, 4)) begin
                        r.kind = dpr_pkg::K_DST_SIZE;
                        r.field_value = accum;
                        dest_len = accum;
                        drop_field();
                        phase = (ck_len != 0) ? dpr_pkg::PH_DSTCK : dpr_pkg::PH_RECLEN;
                    end
                end
                dpr_pkg::PH_DSTCK: begin
                    r.kind = dpr_pkg::K_DST_CK;
                    r.data_byte = b;
                    cnt = cnt + 1;
                    if (cnt >= ck_len) begin
                        cnt = 0;
                        phase = dpr_pkg::PH_RECLEN;
                    end
                end
                dpr_pkg::PH_RECLEN: begin
                    if (take(b, LEN_BYTES)) begin
                        v = accum;
                        drop_field();
                        if (v == {16'd0, marker}) begin
                            phase = dpr_pkg::PH_COPYOFF;
                        end else if (v != 0) begin
                            cnt = v;
                            phase = dpr_pkg::PH_LITERAL;
                        end
                    end
                end
                dpr_pkg::PH_COPYOFF: begin
                    if (take(b, 4)) begin
                        copy_off = accum;
                        drop_field();
                        phase = dpr_pkg::PH_COPYLEN;
                    end
                end
                dpr_pkg::PH_COPYLEN: begin
                    if (take(b, 4)) begin
                        r.kind = dpr_pkg::K_COPY;
                        r.field_value = copy_off;
                        r.copy_length = accum;
                        produced = sat_add(produced, accum);
                        drop_field();
                        phase = dpr_pkg::PH_RECLEN;
                    end
                end
                dpr_pkg::PH_LITERAL: begin
                    r.kind = dpr_pkg::K_LITERAL;
                    r.data_byte = b;
                    produced = sat_add(produced, 32'd1);
                    if (cnt > 0)
                        cnt = cnt - 1;
                    if (cnt == 0)
                        phase = dpr_pkg::PH_RECLEN;
                end
                default: begin
                    phase = (MAGIC_LEN == 0) ? dpr_pkg::PH_CKLEN : dpr_pkg::PH_MAGIC;
                    drop_field();
                end
            endcase
            if (it.last_byte) begin
                r.done_res = 1'b1;
                if (phase != dpr_pkg::PH_RECLEN || cnt != 0)
                    r.status = dpr_pkg::ST_TRUNC;
                else if (produced != dest_len)
                    r.status = dpr_pkg::ST_MISMATCH;
                else
                    r.status = dpr_pkg::ST_OK;
                clear_state();
            end
            pending.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch %0d: %s", errors, msg);
            errors++;
        endtask

        task check_result(dpr_pkg::t_res got);
            dpr_pkg::t_res want;
            if (pending.size() == 0) begin
                report($sformatf("result %h with no transfer pending", got));
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind got %0d want %0d", got.kind, want.kind));
            if (got.data_byte !== want.data_byte)
                report($sformatf("data_byte got %h want %h", got.data_byte, want.data_byte));
            if (got.field_value !== want.field_value)
                report($sformatf("field_value got %h want %h",
                                 got.field_value, want.field_value));
            if (got.copy_length !== want.copy_length)
                report($sformatf("copy_length got %h want %h",
                                 got.copy_length, want.copy_length));
            if (got.done_res !== want.done_res)
                report($sformatf("done_res got %b want %b", got.done_res, want.done_res));
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
        endtask
    endclass

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_stall;
    dpr_pkg::t_item in_item = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    dpr_pkg::t_res  out_res;
    logic           cfg_wr_en = 1'b0;
    logic [15:0]    cfg_wr_data = '0;

    record_scoreboard sb = new();
    logic [7:0]       patch_bytes[$];
    bit               no_idle = 1'b0;
    int               stuck_cycles = 0;

    delta_patch_record_parser #(
        .MAGIC_LEN(MAGIC_LEN),
        .LEN_BYTES(LEN_BYTES)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in_item(in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_res(out_res),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (in_valid && !in_stall)
                sb.parse_byte(in_item);
            if (out_valid && !out_stall)
                sb.check_result(out_res);
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function int draw_gap();
        if (no_idle)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    function void put_le(logic [31:0] v, int n);
        for (int k = 0; k < n; k++)
            patch_bytes.push_back(v[8 * k +: 8]);
    endfunction

    function logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function logic [31:0] rand_copy_len();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 16);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 255);
            2: return $urandom;
            default: return $urandom_range(0, 4096);
        endcase
    endfunction

    // header and records; dest size mostly matches, optionally cut short
    function void build_patch(bit cut);
        logic [31:0] ck;
        logic [31:0] total;
        logic [31:0] len;
        logic [31:0] clen;
        logic [31:0] dst;
        int          dst_at;
        int          keep;
        patch_bytes.delete();
        repeat (MAGIC_LEN) put_le($urandom, 1);
        ck = ($urandom_range(0, 2) == 0) ? 32'd0 : 32'($urandom_range(1, 4));
        put_le(ck, 4);
        put_le(rand_word(), 4);
        repeat (ck) put_le($urandom, 1);
        dst_at = patch_bytes.size();
        put_le(32'd0, 4);
        repeat (ck) put_le($urandom, 1);
        total = 0;
        repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 3) == 0)
                len = {16'd0, sb.marker};
            else
                len = $urandom_range(0, 8);
            put_le(len, LEN_BYTES);
            if (len == {16'd0, sb.marker}) begin
                put_le(rand_word(), 4);
                clen = rand_copy_len();
                put_le(clen, 4);
                total = record_scoreboard::sat_add(total, clen);
            end else begin
                repeat (len) put_le($urandom, 1);
                total = record_scoreboard::sat_add(total, len);
            end
        end
        dst = ($urandom_range(0, 4) == 0) ? total + 32'd1 : total;
        for (int k = 0; k < 4; k++)
            patch_bytes[dst_at + k] = dst[8 * k +: 8];
        if (cut) begin
            keep = $urandom_range(1, patch_bytes.size() - 1);
            while (patch_bytes.size() > keep)
                void'(patch_bytes.pop_back());
        end
    endfunction

    function void build_noise();
        patch_bytes.delete();
        repeat ($urandom_range(1, 24)) put_le($urandom, 1);
    endfunction

    task send_byte(input logic [7:0] b, input logic last);
        int             gap;
        dpr_pkg::t_item it;
        gap = draw_gap();
        it.patch_byte = b;
        it.last_byte = last;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (in_stall);
    endtask

    task send_patch();
        foreach (patch_bytes[i])
            send_byte(patch_bytes[i], i == patch_bytes.size() - 1);
    endtask

    task set_marker(input logic [15:0] v);
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending.size() != 0);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.marker = v;
    endtask

    // one transfer per result, with a long hold-off once the block is well underway
    initial begin : receiver
        int gap;
        int n;
        n = 0;
        wait (rst_n);
        forever begin
            gap = (n == HOLD_AT) ? HOLD_CYCLES : draw_gap();
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            n++;
        end
    end

    initial begin : stimulus
        logic [15:0] marker_list[5];
        logic [15:0] v;
        int          sent;
        int          patch_no;
        int          pick;
        marker_list = '{16'd0, 16'hFFFF, 16'd1, 16'd3, 16'd4096};
        sent = 0;
        patch_no = 0;
        wait (rst_n);
        @(posedge clk);
        set_marker(16'd4096);

        // checksum bytes, a literal, an empty record and a saturating copy
        patch_bytes.delete();
        put_le(32'h00FF_00FF, MAGIC_LEN);
        put_le(32'd1, 4);
        put_le(32'hFFFF_FFFF, 4);
        put_le(32'hFF, 1);
        put_le(32'hFFFF_FFFF, 4);
        put_le(32'h00, 1);
        put_le(32'd1, LEN_BYTES);
        put_le(32'h80, 1);
        put_le(32'd0, LEN_BYTES);
        put_le({16'd0, sb.marker}, LEN_BYTES);
        put_le(32'd0, 4);
        put_le(32'hFFFF_FFFF, 4);
        send_patch();
        sent = patch_bytes.size();

        while (sent < ITEMS) begin
            if (patch_no % 4 == 0) begin
                v = (patch_no / 4 < 5) ? marker_list[patch_no / 4]
                                       : 16'($urandom_range(0, 65535));
                set_marker(v);
            end
            no_idle = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 8)
                build_patch(1'b0);
            else if (pick == 8)
                build_patch(1'b1);
            else
                build_noise();
            sent += patch_bytes.size();
            send_patch();
            patch_no++;
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

>>> filelist.f
rtl/core/dpr_pkg.sv
rtl/core/dpr_front.sv
rtl/core/dpr_fifo.sv
rtl/core/dpr_back.sv
rtl/core/delta_patch_record_parser.sv
tb/sv/delta_patch_record_parser_test.sv
